@@ rtl/core/dac_pkg.sv @@
// shared types and constants for the decimal accumulator machine
// micro-operation codes, microcode word layout and datapath flags; no dependencies
package dac_pkg;

    localparam int unsigned MemWords  = 100;
    localparam int unsigned LastCell  = 99;
    localparam int unsigned LinkBase  = 800;
    localparam int unsigned TruncMod  = 1000;
    localparam int unsigned ShiftMod  = 10000;
    localparam int unsigned WordDiv   = 100;
    localparam int unsigned Radix     = 10;

    localparam int unsigned CardW     = 11;
    localparam int unsigned AccW      = 15;
    localparam int unsigned PcW       = 7;
    localparam int unsigned InW       = 16;
    localparam int unsigned OutW      = 40;
    localparam int unsigned UaddrW    = 5;

    localparam logic [3:0] OP_INP = 4'd0;
    localparam logic [3:0] OP_CLA = 4'd1;
    localparam logic [3:0] OP_ADD = 4'd2;
    localparam logic [3:0] OP_TAC = 4'd3;
    localparam logic [3:0] OP_SFT = 4'd4;
    localparam logic [3:0] OP_OUT = 4'd5;
    localparam logic [3:0] OP_STO = 4'd6;
    localparam logic [3:0] OP_SUB = 4'd7;
    localparam logic [3:0] OP_JMP = 4'd8;
    localparam logic [3:0] OP_HRS = 4'd9;

    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;
    localparam logic [1:0] ST_STOPPED = 2'd3;

    typedef enum logic [4:0] {
        UOP_NOP,
        UOP_FETCH,
        UOP_DECODE,
        UOP_INP,
        UOP_RDXY,
        UOP_RDTRUNC,
        UOP_TRUNC,
        UOP_CLA,
        UOP_ADD,
        UOP_SUB,
        UOP_TAC,
        UOP_SFTINIT,
        UOP_SFTL,
        UOP_SFTR,
        UOP_OUT,
        UOP_STO,
        UOP_JMP,
        UOP_HRS,
        UOP_FIN
    } t_uop;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_LOOP,
        J_DONE
    } t_jmp;

    typedef logic [UaddrW-1:0] t_uaddr;

    localparam t_uaddr UA_FETCH    = 5'd0;
    localparam t_uaddr UA_DECODE   = 5'd1;
    localparam t_uaddr UA_INP      = 5'd2;
    localparam t_uaddr UA_CLA      = 5'd3;
    localparam t_uaddr UA_CLA_LD   = 5'd4;
    localparam t_uaddr UA_ADD      = 5'd5;
    localparam t_uaddr UA_ADD_DO   = 5'd6;
    localparam t_uaddr UA_TAC      = 5'd7;
    localparam t_uaddr UA_TAC_DO   = 5'd8;
    localparam t_uaddr UA_SFT      = 5'd9;
    localparam t_uaddr UA_SFT_L    = 5'd10;
    localparam t_uaddr UA_SFT_R    = 5'd11;
    localparam t_uaddr UA_OUT      = 5'd12;
    localparam t_uaddr UA_OUT_DO   = 5'd13;
    localparam t_uaddr UA_STO      = 5'd14;
    localparam t_uaddr UA_STO_WR   = 5'd15;
    localparam t_uaddr UA_SUB      = 5'd16;
    localparam t_uaddr UA_SUB_DO   = 5'd17;
    localparam t_uaddr UA_JMP      = 5'd18;
    localparam t_uaddr UA_HRS      = 5'd19;
    localparam t_uaddr UA_FIN      = 5'd20;

    typedef struct packed {
        t_uop   op;
        t_jmp   jmp;
        t_uaddr target;
    } t_uword;

    typedef struct packed {
        logic       leave;
        logic       again;
        logic [3:0] opcode;
    } t_dp_flags;

endpackage

@@ rtl/core/decimal_accumulator_cpu.sv @@
// Decimal accumulator machine (CARDIAC style): one instruction per input transfer.
// Usage:
//   The slave channel carries the card word offered to the instruction; one transfer
//   executes exactly one instruction, and INP is the only one that uses the card.
//   The master channel returns one result per instruction: card taken, output word,
//   run status, program counter and accumulator after the step.
//   tready on the slave side is high whenever the sequencer is idle, even while an
//   earlier result still waits in the output register.
//   An instruction runs as microcode steps: fetch, decode, the opcode's routine and a
//   final step that loads the result; SFT adds one shift per step, left for the tens
//   digit and then right for the units digit of the operand. A stopped machine, a pc
//   past the last cell or a negative word skips straight to the final step.
//   The next transfer can be taken in the cycle after the result loads; the rate is set by
//   the sequencer and the synchronous memory's read and write ports (fetch, operand, write-back).
//   If the receiver stalls, the final step waits until the output register is free.
//   Reset clears pc, accumulator, the stop state and every memory cell (through
//   per-cell valid flags, no clearing pass); cell 0 always reads as 1.
//   After HRS or a fault every further transfer reports status 3 until reset.
// depends on dac_pkg and dac_useq
module decimal_accumulator_cpu (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [dac_pkg::InW-1:0]   i_s_axis_tdata,   // [10:0] card_value
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // [0] card_taken, [1] out_valid, [12:2] out_word, [14:13] run_status,
    // [21:15] program_counter, [36:22] accumulator_value
    output logic [dac_pkg::OutW-1:0]  o_m_axis_tdata
);
    import dac_pkg::*;

    localparam logic signed [CardW-1:0] CardMax = CardW'(TruncMod - 1);

    // quotient digit of v / unit for v below ten units
    function automatic logic [3:0] f_digit(input logic [16:0] v, input logic [16:0] unit);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k < 10; k++) begin
            if (v >= 17'(k) * unit) q = 4'(k);
        end
        return q;
    endfunction

    function automatic logic [AccW-1:0] f_mag(input logic signed [AccW-1:0] a);
        return a[AccW-1] ? AccW'(-a) : AccW'(a);
    endfunction

    // remainder by 1000, truncated toward zero
    function automatic logic signed [CardW-1:0] f_rem1000(input logic signed [AccW-1:0] a);
        logic [16:0]             m;
        logic [3:0]              q;
        logic [16:0]             r;
        logic signed [CardW-1:0] rs;
        m  = 17'(f_mag(a));
        q  = f_digit(m, 17'(TruncMod));
        r  = m - 17'(q) * 17'(TruncMod);
        rs = signed'(r[CardW-1:0]);
        return a[AccW-1] ? -rs : rs;
    endfunction

    // (a * 10) rem 10000, sign kept
    function automatic logic signed [AccW-1:0] f_shl(input logic signed [AccW-1:0] a);
        logic [16:0]            p;
        logic [3:0]             q;
        logic [16:0]            r;
        logic signed [AccW-1:0] rs;
        p  = 17'(f_mag(a)) * 17'(Radix);
        q  = f_digit(p, 17'(ShiftMod));
        r  = p - 17'(q) * 17'(ShiftMod);
        rs = signed'(r[AccW-1:0]);
        return a[AccW-1] ? -rs : rs;
    endfunction

    // a / 10 truncated toward zero; reciprocal exact for magnitudes below 10000
    function automatic logic signed [AccW-1:0] f_shr(input logic signed [AccW-1:0] a);
        logic [28:0]            prod;
        logic signed [AccW-1:0] rs;
        prod = 29'(f_mag(a)) * 29'd6554;
        rs   = signed'({2'b00, prod[28:16]});
        return a[AccW-1] ? -rs : rs;
    endfunction

    // architectural state
    logic [PcW-1:0]          r_pc, n_pc;
    logic signed [AccW-1:0]  r_acc, n_acc;
    logic [1:0]              r_stop, n_stop;
    logic [MemWords-1:0]     r_vld;
    logic signed [CardW-1:0] r_mem [0:MemWords-1];

    // working registers
    logic signed [CardW-1:0] r_card;
    logic [PcW-1:0]          r_xy, n_xy;
    logic signed [CardW-1:0] r_t, n_t;
    logic [3:0]              r_cnt_l, n_cnt_l;
    logic [3:0]              r_cnt_r, n_cnt_r;
    logic                    r_res_taken, n_res_taken;
    logic                    r_res_ovalid, n_res_ovalid;
    logic signed [CardW-1:0] r_res_oword, n_res_oword;
    logic [1:0]              r_res_status, n_res_status;
    logic signed [CardW-1:0] r_rd_data;
    logic                    r_rd_vld;
    logic                    r_rd_one;
    logic                    r_o_valid;
    logic [OutW-1:0]         r_o_tdata;

    logic                    busy;
    logic                    in_xfer;
    logic                    out_free;
    logic                    out_load;
    t_uop                    uop;
    t_dp_flags               flags;
    logic                    fault;
    logic                    wr_en;
    logic [PcW-1:0]          rd_addr;
    logic [PcW-1:0]          wr_addr;
    logic signed [CardW-1:0] wr_val;
    logic signed [CardW-1:0] wr_data;
    logic                    wr_fault;
    logic [16:0]             wr_v17;
    logic [3:0]              wr_q;
    logic [16:0]             wr_m;
    logic [CardW-1:0]        link_val;
    logic signed [CardW-1:0] rd_word;
    logic [16:0]             ir17;
    logic [3:0]              dec_op;
    logic [PcW-1:0]          dec_xy;
    logic [3:0]              sft_q;
    logic signed [CardW-1:0] acc_rem;
    logic signed [AccW-1:0]  acc_shl;
    logic signed [AccW-1:0]  acc_shr;

    dac_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_busy     (busy),
        .o_uop      (uop)
    );

    assign o_s_axis_tready = !busy;
    assign in_xfer         = i_s_axis_tvalid && !busy;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign out_load        = (uop == UOP_FIN) && out_free;

    // cell 0 is wired to 1, unwritten cells read as zero
    assign rd_word = r_rd_one ? CardW'(1) : (r_rd_vld ? r_rd_data : '0);

    assign ir17   = 17'(rd_word[CardW-2:0]);
    assign dec_op = f_digit(ir17, 17'(WordDiv));
    assign dec_xy = PcW'(ir17 - 17'(dec_op) * 17'(WordDiv));
    assign sft_q  = f_digit(17'(r_xy), 17'(Radix));

    assign acc_rem = f_rem1000(r_acc);
    assign acc_shl = f_shl(r_acc);
    assign acc_shr = f_shr(r_acc);

    // write port operands
    always_comb begin
        wr_addr = (uop == UOP_JMP) ? PcW'(LastCell) : r_xy;
        case (uop)
            UOP_INP: wr_val = r_card;
            UOP_JMP: wr_val = signed'(CardW'(r_pc));
            default: wr_val = r_t;
        endcase
    end

    assign wr_fault = (wr_addr == '0) || ((wr_addr == PcW'(LastCell)) && wr_val[CardW-1]);
    assign wr_v17   = 17'(wr_val[CardW-2:0]);
    assign wr_q     = f_digit(wr_v17, 17'(WordDiv));
    assign wr_m     = wr_v17 - 17'(wr_q) * 17'(WordDiv);
    assign link_val = CardW'(LinkBase) + wr_m[CardW-1:0];
    assign wr_data  = (wr_addr == PcW'(LastCell)) ? signed'(link_val) : wr_val;

    always_comb begin
        n_pc         = r_pc;
        n_acc        = r_acc;
        n_stop       = r_stop;
        n_xy         = r_xy;
        n_t          = r_t;
        n_cnt_l      = r_cnt_l;
        n_cnt_r      = r_cnt_r;
        n_res_taken  = r_res_taken;
        n_res_ovalid = r_res_ovalid;
        n_res_oword  = r_res_oword;
        n_res_status = r_res_status;
        rd_addr      = r_xy;
        wr_en        = 1'b0;
        fault        = 1'b0;
        flags.leave  = 1'b0;
        flags.again  = 1'b0;
        flags.opcode = dec_op;
        case (uop)
            UOP_FETCH: begin
                n_res_taken  = 1'b0;
                n_res_ovalid = 1'b0;
                n_res_oword  = '0;
                n_res_status = ST_RUN;
                if (r_stop != ST_RUN) begin
                    n_res_status = ST_STOPPED;
                    flags.leave  = 1'b1;
                end else if (r_pc > PcW'(LastCell)) begin
                    fault = 1'b1;
                end else begin
                    rd_addr = r_pc;
                    n_pc    = r_pc + PcW'(1);
                end
            end
            UOP_DECODE: begin
                if (rd_word[CardW-1]) begin
                    fault = 1'b1;
                end else begin
                    n_xy = dec_xy;
                end
            end
            UOP_INP: begin
                n_res_taken = 1'b1;
                if ((r_card > CardMax) || (r_card < -CardMax) || wr_fault) begin
                    fault = 1'b1;
                end else begin
                    wr_en = 1'b1;
                end
            end
            UOP_RDXY: ;
            UOP_RDTRUNC: n_t = acc_rem;
            UOP_TRUNC:   n_t = acc_rem;
            UOP_CLA:     n_acc = AccW'(rd_word);
            UOP_ADD:     n_acc = AccW'(r_t) + AccW'(rd_word);
            UOP_SUB:     n_acc = AccW'(r_t) - AccW'(rd_word);
            UOP_TAC: begin
                if (r_t[CardW-1]) begin
                    n_pc = r_xy;
                end
            end
            UOP_SFTINIT: begin
                n_cnt_l = sft_q;
                n_cnt_r = 4'(r_xy - PcW'(sft_q) * PcW'(Radix));
            end
            UOP_SFTL: begin
                flags.again = (r_cnt_l != '0);
                if (r_cnt_l != '0) begin
                    n_acc   = acc_shl;
                    n_cnt_l = r_cnt_l - 4'd1;
                end
            end
            UOP_SFTR: begin
                flags.again = (r_cnt_r != '0);
                if (r_cnt_r != '0) begin
                    n_acc   = acc_shr;
                    n_cnt_r = r_cnt_r - 4'd1;
                end
            end
            UOP_OUT: begin
                n_res_ovalid = 1'b1;
                n_res_oword  = rd_word;
            end
            UOP_STO: begin
                if (wr_fault) begin
                    fault = 1'b1;
                end else begin
                    wr_en = 1'b1;
                end
            end
            UOP_JMP: begin
                if (wr_fault) begin
                    fault = 1'b1;
                end else begin
                    wr_en = 1'b1;
                    n_pc  = r_xy;
                end
            end
            UOP_HRS: begin
                n_pc         = r_xy;
                n_res_status = ST_HALT;
                n_stop       = ST_HALT;
            end
            default: ;
        endcase
        // a fault leaves memory and accumulator as they were
        if (fault) begin
            n_res_status = ST_FAULT;
            n_stop       = ST_FAULT;
            n_res_ovalid = 1'b0;
            n_res_oword  = '0;
            flags.leave  = 1'b1;
        end
    end

    // word store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
        r_rd_one  <= (rd_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_pc      <= '0;
            r_acc     <= '0;
            r_stop    <= ST_RUN;
            r_o_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            r_pc   <= n_pc;
            r_acc  <= n_acc;
            r_stop <= n_stop;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_card <= signed'(i_s_axis_tdata[CardW-1:0]);
        end
        r_xy         <= n_xy;
        r_t          <= n_t;
        r_cnt_l      <= n_cnt_l;
        r_cnt_r      <= n_cnt_r;
        r_res_taken  <= n_res_taken;
        r_res_ovalid <= n_res_ovalid;
        r_res_oword  <= n_res_oword;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_o_tdata <= {3'b000, r_acc, r_pc, r_res_status, r_res_oword,
                          r_res_ovalid, r_res_taken};
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_tdata;

endmodule

@@ rtl/core/dac_useq.sv @@
// microcode sequencer: step counter, control store and jump logic
// depends on dac_pkg for the micro-op codes and the control word layout
module dac_useq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_out_free,
    input  dac_pkg::t_dp_flags i_flags,
    output logic               o_busy,
    output dac_pkg::t_uop      o_uop
);
    import dac_pkg::*;

    logic   r_busy, n_busy;
    t_uaddr r_upc, n_upc;
    t_uword uw;

    function automatic t_uword f_urom(input t_uaddr a);
        t_uword w;
        case (a)
            UA_FETCH:  w = '{UOP_FETCH,   J_NEXT,     UA_DECODE};
            UA_DECODE: w = '{UOP_DECODE,  J_DISPATCH, UA_FIN};
            UA_INP:    w = '{UOP_INP,     J_GOTO,     UA_FIN};
            UA_CLA:    w = '{UOP_RDXY,    J_NEXT,     UA_CLA_LD};
            UA_CLA_LD: w = '{UOP_CLA,     J_GOTO,     UA_FIN};
            UA_ADD:    w = '{UOP_RDTRUNC, J_NEXT,     UA_ADD_DO};
            UA_ADD_DO: w = '{UOP_ADD,     J_GOTO,     UA_FIN};
            UA_TAC:    w = '{UOP_TRUNC,   J_NEXT,     UA_TAC_DO};
            UA_TAC_DO: w = '{UOP_TAC,     J_GOTO,     UA_FIN};
            UA_SFT:    w = '{UOP_SFTINIT, J_NEXT,     UA_SFT_L};
            UA_SFT_L:  w = '{UOP_SFTL,    J_LOOP,     UA_SFT_R};
            UA_SFT_R:  w = '{UOP_SFTR,    J_LOOP,     UA_FIN};
            UA_OUT:    w = '{UOP_RDXY,    J_NEXT,     UA_OUT_DO};
            UA_OUT_DO: w = '{UOP_OUT,     J_GOTO,     UA_FIN};
            UA_STO:    w = '{UOP_TRUNC,   J_NEXT,     UA_STO_WR};
            UA_STO_WR: w = '{UOP_STO,     J_GOTO,     UA_FIN};
            UA_SUB:    w = '{UOP_RDTRUNC, J_NEXT,     UA_SUB_DO};
            UA_SUB_DO: w = '{UOP_SUB,     J_GOTO,     UA_FIN};
            UA_JMP:    w = '{UOP_JMP,     J_GOTO,     UA_FIN};
            UA_HRS:    w = '{UOP_HRS,     J_GOTO,     UA_FIN};
            UA_FIN:    w = '{UOP_FIN,     J_DONE,     UA_FIN};
            default:   w = '{UOP_NOP,     J_GOTO,     UA_FIN};
        endcase
        return w;
    endfunction

    // entry point of each instruction's routine
    function automatic t_uaddr f_entry(input logic [3:0] op);
        t_uaddr a;
        case (op)
            OP_INP:  a = UA_INP;
            OP_CLA:  a = UA_CLA;
            OP_ADD:  a = UA_ADD;
            OP_TAC:  a = UA_TAC;
            OP_SFT:  a = UA_SFT;
            OP_OUT:  a = UA_OUT;
            OP_STO:  a = UA_STO;
            OP_SUB:  a = UA_SUB;
            OP_JMP:  a = UA_JMP;
            OP_HRS:  a = UA_HRS;
            default: a = UA_FIN;
        endcase
        return a;
    endfunction

    always_comb begin
        uw     = f_urom(r_upc);
        o_uop  = r_busy ? uw.op : UOP_NOP;
        n_busy = r_busy;
        n_upc  = r_upc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_upc  = UA_FETCH;
            end
        end else if (i_flags.leave) begin
            n_upc = UA_FIN;
        end else begin
            case (uw.jmp)
                J_NEXT:     n_upc = r_upc + 5'd1;
                J_GOTO:     n_upc = uw.target;
                J_DISPATCH: n_upc = f_entry(i_flags.opcode);
                J_LOOP:     n_upc = i_flags.again ? r_upc : uw.target;
                J_DONE: begin
                    if (i_out_free) begin
                        n_busy = 1'b0;
                    end
                end
                default:    n_upc = UA_FIN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_upc  <= UA_FETCH;
        end else begin
            r_busy <= n_busy;
            r_upc  <= n_upc;
        end
    end

    assign o_busy = r_busy;

endmodule

@@ sim/tb_decimal_accumulator_cpu.sv @@
`timescale 1ns / 100ps
// self-checking testbench for decimal_accumulator_cpu: cards are steered through the bootstrap
// loader so the machine keeps running, every result is checked against a predicted machine
// depends on dac_pkg and the decimal_accumulator_cpu rtl
module tb_decimal_accumulator_cpu;
    import dac_pkg::*;

    localparam int Cells       = MemWords;
    localparam int Top         = LastCell;
    localparam int Link        = LinkBase;
    localparam int Tmod        = TruncMod;
    localparam int Smod        = ShiftMod;
    localparam int Wdiv        = WordDiv;
    localparam int Rdx         = Radix;
    localparam int LoopCell    = 2;     // holds the jump back to cell 0
    localparam int ProgBase    = 10;
    localparam int DataBase    = 50;
    localparam int RandomItems = 1240;
    localparam int QuietFrom   = 1100;
    localparam int StoppedTail = 8;
    localparam int DrainCycles = 32;

    typedef logic [CardW-1:0] card_bits_t;

    typedef struct packed {
        logic             card_taken;
        logic             out_valid;
        card_bits_t       out_word;
        logic [1:0]       run_status;
        logic [PcW-1:0]   pc;
        logic [AccW-1:0]  acc;
    } step_result_t;

    // one loader pass: the word placed in cell 1, and the card it takes if it is an INP
    typedef struct {
        int word;
        int data;
    } loader_slot_t;

    class machine_scoreboard;
        int           word_mem[Cells];
        int           pc_q;
        int           acc_q;
        logic [1:0]   stop_q;
        step_result_t pending_results[$];
        int           mismatches;
        int           compared;
        int           op_seen[10];

        function new();
            foreach (word_mem[i]) word_mem[i] = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
            pc_q = 0;
            acc_q = 0;
            stop_q = ST_RUN;
            mismatches = 0;
            compared = 0;
        endfunction

        function int read_word(int addr);
            return (addr == 0) ? 1 : word_mem[addr];
        endfunction

        function bit store_word(int addr, int value);
            if (addr < 1 || addr > Top) return 1'b0;
            if (addr == Top) begin
                if (value < 0) return 1'b0;
                value = Link + value % Wdiv;
            end
            word_mem[addr] = value;
            return 1'b1;
        endfunction

        // executes one instruction on the predicted machine and queues its result
        function void note_card(card_bits_t card);
            step_result_t r;
            int           ir;
            int           xy;
            int           k;
            int           value;
            logic [3:0]   opc;
            bit           ok;
            r = '0;
            ok = 1'b1;
            r.run_status = ST_RUN;
            if (stop_q != ST_RUN) begin
                r.run_status = ST_STOPPED;
            end else if (pc_q > Top) begin
                ok = 1'b0;
            end else begin
                ir = read_word(pc_q);
                pc_q++;
                if (ir < 0) begin
                    ok = 1'b0;
                end else begin
                    xy = ir % Wdiv;
                    opc = 4'(ir / Wdiv);
                    op_seen[opc]++;
                    case (opc)
                        OP_INP: begin
                            value = int'($signed(card));
                            r.card_taken = 1'b1;
                            if (value <= -Tmod || value >= Tmod) ok = 1'b0;
                            else ok = store_word(xy, value);
                        end
                        OP_CLA: acc_q = read_word(xy);
                        OP_ADD: acc_q = acc_q % Tmod + read_word(xy);
                        OP_TAC: if (acc_q % Tmod < 0) pc_q = xy;
                        OP_SFT: begin
                            for (k = xy / Rdx; k > 0; k--) acc_q = (acc_q * Rdx) % Smod;
                            for (k = xy % Rdx; k > 0; k--) acc_q = acc_q / Rdx;
                        end
                        OP_OUT: begin
                            r.out_valid = 1'b1;
                            r.out_word = card_bits_t'(read_word(xy));
                        end
                        OP_STO: ok = store_word(xy, acc_q % Tmod);
                        OP_SUB: acc_q = acc_q % Tmod - read_word(xy);
                        OP_JMP: begin
                            ok = store_word(Top, pc_q);
                            if (ok) pc_q = xy;
                        end
                        OP_HRS: begin
                            pc_q = xy;
                            r.run_status = ST_HALT;
                            stop_q = ST_HALT;
                        end
                        default: ok = 1'b0;
                    endcase
                end
            end
            if (!ok) begin
                r.run_status = ST_FAULT;
                stop_q = ST_FAULT;
                r.out_valid = 1'b0;
                r.out_word = '0;
            end
            r.pc = PcW'(pc_q);
            r.acc = AccW'(acc_q);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OutW-1:0] d);
            step_result_t want;
            compared++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result %0d arrived with none expected: %h",
                                               compared, d);
                return;
            end
            want = pending_results.pop_front();
            if (d[0] !== want.card_taken || d[1] !== want.out_valid
                || d[12:2] !== want.out_word || d[14:13] !== want.run_status
                || d[21:15] !== want.pc || d[36:22] !== want.acc) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch (expected/actual): taken %0b/%0b out %0b/%0b",
                             compared, want.card_taken, d[0], want.out_valid, d[1]);
                    $display("  word %0d/%0d status %0d/%0d pc %0d/%0d acc %0d/%0d",
                             $signed(want.out_word), $signed(d[12:2]),
                             want.run_status, d[14:13], want.pc, d[21:15],
                             $signed(want.acc), $signed(d[36:22]));
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                card_valid;
    logic                card_ready;
    logic [InW-1:0]      card_data;
    logic                res_valid;
    logic                res_ready = 1'b0;
    logic [OutW-1:0]     res_data;

    machine_scoreboard   sb = new();
    loader_slot_t        load_q[$];
    bit                  held_valid;
    int                  held_card;
    bit                  finishing;
    int                  items_sent;
    int                  stall_rate;
    int                  stall_left;

    decimal_accumulator_cpu u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (card_valid),
        .o_s_axis_tready (card_ready),
        .i_s_axis_tdata  (card_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    always #5 clk = ~clk;

    // receiver side: random stall bursts, none while the rate is zero
    always @(posedge clk) begin
        if (!rst_n || stall_rate == 0) begin
            res_ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_rate / 2) begin
            stall_left <= $urandom_range(0, 16);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) sb.check_result(res_data);
    end

    function automatic int encode_word(logic [3:0] op, int xy);
        return int'(op) * Wdiv + xy;
    endfunction

    function automatic int data_card(int xy);
        int v;
        case ($urandom_range(0, 7))
            0: v = Tmod - 1;
            1: v = 1 - Tmod;
            2: v = int'($urandom_range(0, 2)) - 1;
            default: v = int'($urandom_range(0, 2 * Tmod - 2)) - (Tmod - 1);
        endcase
        // cell 99 only accepts non-negative values while running
        if (xy == Top && v < 0) v = -v;
        return v;
    endfunction

    // straight-line program at ProgBase, loaded card by card, then entered by a jump
    function automatic void queue_program();
        int         len;
        int         xy;
        logic [3:0] op;
        len = $urandom_range(3, 12);
        for (int i = 0; i < len; i++) begin
            op = 4'($urandom_range(0, 7));
            xy = $urandom_range(0, Top);
            case (op)
                OP_INP: xy = $urandom_range(DataBase, Top);
                OP_STO: xy = $urandom_range(DataBase, Top - 1);
                OP_TAC: xy = 0;
                default: ;
            endcase
            load_q.push_back('{encode_word(OP_INP, ProgBase + i), encode_word(op, xy)});
        end
        load_q.push_back('{encode_word(OP_INP, ProgBase + len), encode_word(OP_JMP, 0)});
        load_q.push_back('{encode_word(OP_JMP, ProgBase), 0});
    endfunction

    function automatic void queue_random_instruction();
        logic [3:0] op;
        int         xy;
        if ($urandom_range(0, 9) == 0) begin
            queue_program();
            return;
        end
        op = 4'($urandom_range(0, 8));
        xy = $urandom_range(0, Top);
        case (op)
            OP_INP, OP_STO: begin
                // keep off cell 0 and the loop cell
                if (xy == 0 || xy == LoopCell) xy = xy + 3;
                if (op == OP_STO && xy == Top && sb.acc_q % Tmod < 0) xy = Top - 1;
            end
            OP_TAC, OP_JMP: xy = $urandom_range(0, 1) ? 0 : LoopCell;
            default: ;
        endcase
        load_q.push_back('{encode_word(op, xy), data_card(xy)});
    endfunction

    // ends the run: a halt or one of the fault conditions
    function automatic void queue_stop_sequence();
        int neg;
        neg = -int'($urandom_range(1, Tmod - 1));
        case ($urandom_range(0, 9))
            0, 1, 2: load_q.push_back('{encode_word(OP_HRS, $urandom_range(0, Top)), 0});
            3: load_q.push_back('{encode_word(OP_INP, 0), data_card(0)});
            4: load_q.push_back('{encode_word(OP_INP, DataBase),
                                  $urandom_range(0, 1) ? int'($urandom_range(Tmod, 1023))
                                                       : -int'($urandom_range(Tmod, 1024))});
            5: load_q.push_back('{encode_word(OP_STO, 0), 0});
            6: begin
                load_q.push_back('{encode_word(OP_INP, DataBase), neg});
                load_q.push_back('{encode_word(OP_CLA, DataBase), 0});
                load_q.push_back('{encode_word(OP_STO, Top), 0});
            end
            7: load_q.push_back('{encode_word(OP_INP, Top), neg});
            default: load_q.push_back('{neg, 0});
        endcase
    endfunction

    // chooses the card for the instruction the machine will execute next
    function automatic card_bits_t next_card();
        loader_slot_t slot;
        int           w;
        if (sb.stop_q != ST_RUN) return card_bits_t'($urandom);
        if (sb.pc_q == 0) begin
            if (load_q.size() == 0) begin
                if (finishing) queue_stop_sequence();
                else queue_random_instruction();
            end
            slot = load_q.pop_front();
            held_valid = slot.word >= 0 && slot.word / Wdiv == OP_INP;
            held_card = slot.data;
            return card_bits_t'(slot.word);
        end
        w = sb.read_word(sb.pc_q);
        if (w >= 0 && w / Wdiv == OP_INP) begin
            if (held_valid) begin
                held_valid = 1'b0;
                return card_bits_t'(held_card);
            end
            return card_bits_t'(data_card(w % Wdiv));
        end
        return card_bits_t'($urandom);
    endfunction

    task automatic send_card(input card_bits_t card);
        card_valid <= 1'b1;
        card_data <= {{(InW - CardW){1'b0}}, card};
        do @(posedge clk); while (!card_ready);
        sb.note_card(card);
        items_sent++;
        if (stall_rate != 0 && $urandom_range(0, 99) < 2 * stall_rate) begin
            card_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    initial begin
        int ops_hit;
        rst_n = 1'b0;
        card_valid = 1'b0;
        card_data = '0;
        stall_rate = 0;
        items_sent = 0;
        finishing = 1'b0;
        held_valid = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bootstrap the loop cell, then one pass over every opcode except HRS
        load_q.push_back('{encode_word(OP_INP, LoopCell), encode_word(OP_JMP, 0)});
        load_q.push_back('{encode_word(OP_INP, 5), 1 - Tmod});
        load_q.push_back('{encode_word(OP_CLA, 5), 0});
        load_q.push_back('{encode_word(OP_TAC, 0), 0});
        load_q.push_back('{encode_word(OP_SFT, 11), 0});
        load_q.push_back('{encode_word(OP_ADD, 5), 0});
        load_q.push_back('{encode_word(OP_SUB, 0), 0});
        load_q.push_back('{encode_word(OP_STO, 7), 0});
        load_q.push_back('{encode_word(OP_OUT, 0), 0});

        while (sb.stop_q == ST_RUN) begin
            if (items_sent >= RandomItems) finishing = 1'b1;
            if (items_sent >= QuietFrom) begin
                stall_rate <= 0;
            end else if (items_sent % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: stall_rate <= 0;
                    1: stall_rate <= 5;
                    default: stall_rate <= 20;
                endcase
            end
            send_card(next_card());
        end
        repeat (StoppedTail) send_card(next_card());
        card_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        ops_hit = 0;
        foreach (sb.op_seen[i]) if (sb.op_seen[i] != 0) ops_hit++;
        $display("%0d transfers in, %0d results compared, %0d of 10 opcodes executed",
                 items_sent, sb.compared, ops_hit);
        $display("machine left in stop state %0d, %0d mismatches", sb.stop_q, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sb.pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
